[sv/pfc_pkg.sv]
`timescale 1ns / 1ps
package pfc_pkg;

  localparam int SqDim    = 5;
  localparam int SqCells  = SqDim * SqDim;
  localparam int CodeW    = 5;
  localparam int SqW      = SqCells * CodeW;
  localparam int CfgW     = 50;
  localparam int QDepth   = 4;
  localparam int QAw      = $clog2(QDepth);

  localparam logic [CodeW-1:0] CODE_I = 5'd8;
  localparam logic [CodeW-1:0] CODE_J = 5'd9;
  localparam logic [CodeW-1:0] CODE_Q = 5'd16;
  localparam logic [CodeW-1:0] CODE_X = 5'd23;

  localparam logic [7:0] ASCII_UA = 8'h41;
  localparam logic [7:0] ASCII_UZ = 8'h5A;
  localparam logic [7:0] ASCII_LA = 8'h61;
  localparam logic [7:0] ASCII_LZ = 8'h7A;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_ROWS01 = 2'd1,
    CFG_ROWS23 = 2'd2,
    CFG_ROW4   = 2'd3
  } cfg_idx_t;

  // one pair to substitute, or an empty end marker
  typedef struct packed {
    logic             empty;
    logic             last;
    logic             dec;
    logic [CodeW-1:0] a;
    logic [CodeW-1:0] b;
  } job_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  function automatic logic [CodeW-1:0] split_filler(input logic [CodeW-1:0] code);
    return (code == CODE_X) ? CODE_Q : CODE_X;
  endfunction

  // first matching cell wins; no match gives cell 0
  function automatic pos_t locate(input logic [SqW-1:0] sq, input logic [CodeW-1:0] code);
    pos_t p;
    p = '0;
    for (int r = SqDim - 1; r >= 0; r--) begin
      for (int c = SqDim - 1; c >= 0; c--) begin
        if (sq[(r * SqDim + c) * CodeW +: CodeW] == code) begin
          p.row = 3'(r);
          p.col = 3'(c);
        end
      end
    end
    return p;
  endfunction

  // one step along a row or column, wrapping
  function automatic logic [2:0] step5(input logic [2:0] x, input logic dec);
    logic [2:0] y;
    if (dec) begin
      y = (x == 3'd0) ? 3'(SqDim - 1) : x - 3'd1;
    end else begin
      y = (x == 3'(SqDim - 1)) ? 3'd0 : x + 3'd1;
    end
    return y;
  endfunction

  function automatic logic [CodeW-1:0] cell_code(input logic [SqW-1:0] sq, input pos_t p);
    logic [4:0] idx;
    logic [6:0] off;
    idx = 5'(p.row) * 5'(SqDim) + 5'(p.col);
    off = 7'(idx) * 7'(CodeW);
    return sq[off +: CodeW];
  endfunction

endpackage

[sv/pfc_front.sv]
`timescale 1ns / 1ps
module pfc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                decrypt_mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_in,
  input  logic                end_of_text,
  output logic                push,
  output pfc_pkg::job_t       push_job,
  input  logic                q_full
);
  import pfc_pkg::*;

  logic             pend_v_r, pend_v_nxt;
  logic [CodeW-1:0] pend_l_r, pend_l_nxt;
  logic             hold_v_r, hold_v_nxt;
  job_t             hold_r, hold_nxt;

  logic             acc;
  logic             is_letter;
  logic [CodeW-1:0] c;
  logic             ja_v, jb_v;
  job_t             ja, jb, first;

  assign in_ready = !hold_v_r && !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    is_letter = 1'b0;
    c         = '0;
    if (char_in >= ASCII_UA && char_in <= ASCII_UZ) begin
      is_letter = 1'b1;
      c         = CodeW'(char_in - ASCII_UA);
    end else if (char_in >= ASCII_LA && char_in <= ASCII_LZ) begin
      is_letter = 1'b1;
      c         = CodeW'(char_in - ASCII_LA);
    end
    if (is_letter && c == CODE_J) begin
      c = CODE_I;
    end

    pend_v_nxt = pend_v_r;
    pend_l_nxt = pend_l_r;
    ja_v       = 1'b0;
    jb_v       = 1'b0;
    ja         = '{empty: 1'b0, last: 1'b0, dec: decrypt_mode, a: pend_l_r, b: c};
    jb         = '{empty: 1'b0, last: 1'b1, dec: decrypt_mode, a: '0, b: '0};

    if (is_letter) begin
      if (!pend_v_r) begin
        pend_v_nxt = 1'b1;
        pend_l_nxt = c;
      end else if (!decrypt_mode && pend_l_r == c) begin
        ja_v       = 1'b1;
        ja.b       = split_filler(pend_l_r);
        pend_l_nxt = c;
      end else begin
        ja_v       = 1'b1;
        pend_v_nxt = 1'b0;
      end
    end

    if (end_of_text) begin
      if (pend_v_nxt) begin
        jb_v       = 1'b1;
        jb.a       = pend_l_nxt;
        jb.b       = decrypt_mode ? CODE_X : split_filler(pend_l_nxt);
        pend_v_nxt = 1'b0;
      end else if (!ja_v) begin
        jb_v       = 1'b1;
        jb.empty   = 1'b1;
      end
    end

    first    = ja_v ? ja : jb;
    if (ja_v && !jb_v) begin
      first.last = end_of_text;
    end

    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    push       = 1'b0;
    push_job   = first;
    if (hold_v_r) begin
      push_job = hold_r;
      if (!q_full) begin
        push       = 1'b1;
        hold_v_nxt = 1'b0;
      end
    end else if (acc) begin
      push = ja_v || jb_v;
      if (ja_v && jb_v) begin
        hold_v_nxt = 1'b1;
        hold_nxt   = jb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      pend_l_r <= '0;
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      if (acc) begin
        pend_v_r <= pend_v_nxt;
        pend_l_r <= pend_l_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

[sv/pfc_fifo.sv]
`timescale 1ns / 1ps
module pfc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_v,
  output pfc_pkg::job_t head_job
);
  import pfc_pkg::*;

  job_t           mem [QDepth];
  logic [QAw-1:0] wp_r, wp_nxt;
  logic [QAw-1:0] rp_r, rp_nxt;
  logic [QAw:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QAw + 1)'(QDepth));
  assign head_v   = (cnt_r != '0);
  assign head_job = mem[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_job;
    end
  end

endmodule

[sv/pfc_back.sv]
`timescale 1ns / 1ps
module pfc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pfc_pkg::SqW-1:0]    square,
  input  logic                       head_v,
  input  pfc_pkg::job_t              head_job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pfc_pkg::CodeW-1:0]  letter,
  output logic                       has_letter,
  output logic                       last_out
);
  import pfc_pkg::*;

  // locate stage
  logic l_v_r, l_v_nxt;
  logic l_empty_r, l_last_r, l_dec_r;
  pos_t l_p1_r, l_p2_r;

  // result stage: two words per pair
  logic p_v_r, p_v_nxt;
  logic p_half_r, p_half_nxt;
  logic p_empty_r, p_last_r;
  pos_t p_o1_r, p_o2_r;

  logic l_adv, p_load, p_done, p_free, l_free;
  pos_t o1, o2;

  assign p_done = p_v_r && out_ready && (p_empty_r || p_half_r);
  assign p_free = !p_v_r || p_done;
  assign l_adv  = l_v_r && p_free;
  assign l_free = !l_v_r || l_adv;
  assign pop    = head_v && l_free;
  assign p_load = l_adv;

  always_comb begin
    if (l_p1_r.row == l_p2_r.row) begin
      o1 = '{row: l_p1_r.row, col: step5(l_p1_r.col, l_dec_r)};
      o2 = '{row: l_p2_r.row, col: step5(l_p2_r.col, l_dec_r)};
    end else if (l_p1_r.col == l_p2_r.col) begin
      o1 = '{row: step5(l_p1_r.row, l_dec_r), col: l_p1_r.col};
      o2 = '{row: step5(l_p2_r.row, l_dec_r), col: l_p2_r.col};
    end else begin
      o1 = '{row: l_p1_r.row, col: l_p2_r.col};
      o2 = '{row: l_p2_r.row, col: l_p1_r.col};
    end
  end

  always_comb begin
    l_v_nxt    = l_free ? head_v : l_v_r;
    p_v_nxt    = p_load ? 1'b1 : (p_done ? 1'b0 : p_v_r);
    p_half_nxt = p_half_r;
    if (p_load) begin
      p_half_nxt = 1'b0;
    end else if (p_v_r && out_ready) begin
      p_half_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_v_r    <= 1'b0;
      p_v_r    <= 1'b0;
      p_half_r <= 1'b0;
    end else begin
      l_v_r    <= l_v_nxt;
      p_v_r    <= p_v_nxt;
      p_half_r <= p_half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      l_empty_r <= head_job.empty;
      l_last_r  <= head_job.last;
      l_dec_r   <= head_job.dec;
      l_p1_r    <= locate(square, head_job.a);
      l_p2_r    <= locate(square, head_job.b);
    end
    if (p_load) begin
      p_empty_r <= l_empty_r;
      p_last_r  <= l_last_r;
      p_o1_r    <= o1;
      p_o2_r    <= o2;
    end
  end

  assign out_valid  = p_v_r;
  assign has_letter = !p_empty_r;
  assign last_out   = p_last_r && (p_empty_r || p_half_r);
  assign letter     = p_empty_r ? '0 : cell_code(square, p_half_r ? p_o2_r : p_o1_r);

endmodule

[sv/playfair_digraph_cipher_unit.sv]
`timescale 1ns / 1ps
// A pair's letter words leave through the queue, the locate stage and the result stage.
// One input word is taken every cycle while the queue has room and no pair is held;
// each pair drains as two output words, the second once the first is taken, so a letter
// stream runs at one byte per cycle while the output is ready. A byte that makes a pair
// alone (split doubled letter) gives two words; a byte yielding two pairs holds input.
// Reset (synchronous, rst_n low) clears the pending letter, queue, pipeline and registers.
module playfair_digraph_cipher_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] char_in
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [4:0] letter, [7:5] zero
  output logic                      out_tuser,  // [0] has_letter
  output logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [pfc_pkg::CfgW-1:0]  cfg_wdata
);
  import pfc_pkg::*;

  logic          mode_r;
  logic [49:0]   rows01_r, rows23_r;
  logic [24:0]   row4_r;
  logic [SqW-1:0] square;

  logic          push, q_full, pop, head_v;
  job_t          push_job, head_job;
  logic [CodeW-1:0] letter;

  assign square = {row4_r, rows23_r, rows01_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      rows01_r <= '0;
      rows23_r <= '0;
      row4_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MODE:   mode_r   <= cfg_wdata[0];
        CFG_ROWS01: rows01_r <= cfg_wdata[49:0];
        CFG_ROWS23: rows23_r <= cfg_wdata[49:0];
        CFG_ROW4:   row4_r   <= cfg_wdata[24:0];
        default:    mode_r   <= mode_r;
      endcase
    end
  end

  pfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .decrypt_mode (mode_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .char_in      (in_tdata),
    .end_of_text  (in_tlast),
    .push         (push),
    .push_job     (push_job),
    .q_full       (q_full)
  );

  pfc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_v   (head_v),
    .head_job (head_job)
  );

  pfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .square     (square),
    .head_v     (head_v),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .letter     (letter),
    .has_letter (out_tuser),
    .last_out   (out_tlast)
  );

  assign out_tdata = {3'b000, letter};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import pfc_pkg::*;

  typedef struct packed {
    logic [CodeW-1:0] letter;
    logic             has;
    logic             last;
  } glyph_t;

  typedef struct packed {
    int               setting;
    logic [7:0]       ch;
    logic             eot;
    logic             typed;
    logic [2:0]       n;
    logic [3:0][4:0]  codes;
  } dir_row_t;

  localparam int NO_SET      = -1;
  localparam int SET_STD_ENC = 0;
  localparam int SET_STD_DEC = 1;
  localparam int DIR_ROWS    = 26;
  localparam int PHASE_ITEMS = 42;
  localparam string STD_KEY  = "PLAYFIREXMBCDGHKNOQSTUVWZ";

  // typed rows run on the all-zero square after reset: every letter maps to code 0
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{NO_SET,      "1",   1'b0, 1'b1, 3'd0, '0},
    '{NO_SET,      8'h00, 1'b1, 1'b1, 3'd0, '0},
    '{NO_SET,      "A",   1'b0, 1'b1, 3'd0, '0},
    '{NO_SET,      "A",   1'b1, 1'b1, 3'd4, '0},
    '{SET_STD_ENC, "H",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "i",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "P",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "l",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "e",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "E",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "x",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "X",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "X",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "J",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "@",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "[",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      8'h60, 1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "{",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      8'hFF, 1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "Z",   1'b1, 1'b0, 3'd0, '0},
    '{SET_STD_DEC, "B",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "B",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "m",   1'b0, 1'b0, 3'd0, '0},
    '{SET_STD_ENC, "M",   1'b0, 1'b0, 3'd0, '0},
    '{NO_SET,      "a",   1'b1, 1'b0, 3'd0, '0},
    '{SET_STD_DEC, "q",   1'b1, 1'b0, 3'd0, '0}
  };

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [7:0]      in_tdata;
  logic            in_tlast;
  logic            out_tvalid;
  logic            out_tready;
  logic [7:0]      out_tdata;
  logic            out_tuser;
  logic            out_tlast;
  logic            cfg_we;
  logic [1:0]      cfg_addr;
  logic [CfgW-1:0] cfg_wdata;

  playfair_digraph_cipher_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // cipher state as the block should hold it
  logic             mode_dec;
  logic [SqW-1:0]   key_sq;
  logic             held_valid;
  logic [CodeW-1:0] held_letter;

  glyph_t           cipher_letters_q[$];
  glyph_t [3:0]     step_out;
  int               step_n;
  int               fails;
  int               snd_idle;
  int               rcv_idle;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    glyph_t exp_g;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_letters_q.size() == 0) begin
        $error("unexpected word: letter %0d has_letter %0d last %0d",
               out_tdata[4:0], out_tuser, out_tlast);
        fails++;
      end else begin
        exp_g = cipher_letters_q.pop_front();
        if (out_tdata[4:0] !== exp_g.letter) begin
          $error("letter: expected %0d, got %0d", exp_g.letter, out_tdata[4:0]);
          fails++;
        end
        if (out_tuser !== exp_g.has) begin
          $error("has_letter: expected %0d, got %0d", exp_g.has, out_tuser);
          fails++;
        end
        if (out_tlast !== exp_g.last) begin
          $error("last_out: expected %0d, got %0d", exp_g.last, out_tlast);
          fails++;
        end
      end
    end
  end

  function automatic int find_cell(logic [CodeW-1:0] code);
    for (int k = 0; k < SqCells; k++) begin
      if (key_sq[k*CodeW +: CodeW] == code) return k;
    end
    return 0;
  endfunction

  function automatic logic [CodeW-1:0] filler_for(logic [CodeW-1:0] code);
    return (code == CODE_X) ? CODE_Q : CODE_X;
  endfunction

  task automatic add_glyph(logic [CodeW-1:0] code, logic has);
    step_out[step_n] = '{code, has, 1'b0};
    step_n++;
  endtask

  task automatic substitute(logic [CodeW-1:0] a, logic [CodeW-1:0] b, logic dec);
    int pa, pb, r1, c1, r2, c2, sh, o1, o2;
    pa = find_cell(a);
    pb = find_cell(b);
    r1 = pa / SqDim;
    c1 = pa % SqDim;
    r2 = pb / SqDim;
    c2 = pb % SqDim;
    sh = dec ? SqDim - 1 : 1;
    if (r1 == r2) begin
      o1 = r1 * SqDim + (c1 + sh) % SqDim;
      o2 = r2 * SqDim + (c2 + sh) % SqDim;
    end else if (c1 == c2) begin
      o1 = ((r1 + sh) % SqDim) * SqDim + c1;
      o2 = ((r2 + sh) % SqDim) * SqDim + c2;
    end else begin
      o1 = r1 * SqDim + c2;
      o2 = r2 * SqDim + c1;
    end
    add_glyph(key_sq[o1*CodeW +: CodeW], 1'b1);
    add_glyph(key_sq[o2*CodeW +: CodeW], 1'b1);
  endtask

  task automatic playfair_predict(logic [7:0] ch, logic eot);
    logic [CodeW-1:0] c;
    logic             is_l;
    step_n = 0;
    step_out = '0;
    is_l = 1'b0;
    c = '0;
    if (ch >= ASCII_UA && ch <= ASCII_UZ) begin
      c = CodeW'(ch - ASCII_UA);
      is_l = 1'b1;
    end else if (ch >= ASCII_LA && ch <= ASCII_LZ) begin
      c = CodeW'(ch - ASCII_LA);
      is_l = 1'b1;
    end
    if (is_l && c == CODE_J) c = CODE_I;
    if (is_l) begin
      if (!held_valid) begin
        held_letter = c;
        held_valid = 1'b1;
      end else if (!mode_dec && held_letter == c) begin
        substitute(held_letter, filler_for(held_letter), 1'b0);
        held_letter = c;
      end else begin
        substitute(held_letter, c, mode_dec);
        held_valid = 1'b0;
      end
    end
    if (eot) begin
      if (held_valid) begin
        substitute(held_letter, mode_dec ? CODE_X : filler_for(held_letter), mode_dec);
        held_valid = 1'b0;
      end
      if (step_n == 0) add_glyph('0, 1'b0);
      step_out[step_n-1].last = 1'b1;
    end
  endtask

  task automatic send_word(logic [7:0] ch, logic eot, logic typed, int n,
                           logic [3:0][4:0] codes);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    playfair_predict(ch, eot);
    if (typed) begin
      for (int i = 0; i < n; i++) begin
        cipher_letters_q.push_back('{codes[i], 1'b1, eot && (i == n - 1)});
      end
      if (eot && n == 0) cipher_letters_q.push_back('{'0, 1'b0, 1'b1});
    end else begin
      for (int i = 0; i < step_n; i++) cipher_letters_q.push_back(step_out[i]);
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (cipher_letters_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(logic dec, logic [SqW-1:0] sq);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_MODE;
    cfg_wdata <= {junk[CfgW-2:0], dec};
    @(posedge clk);
    mode_dec = dec;
    cfg_addr  <= CFG_ROWS01;
    cfg_wdata <= sq[49:0];
    @(posedge clk);
    cfg_addr  <= CFG_ROWS23;
    cfg_wdata <= sq[99:50];
    @(posedge clk);
    cfg_addr  <= CFG_ROW4;
    cfg_wdata <= {junk[63:39], sq[124:100]};
    @(posedge clk);
    key_sq = sq;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SqW-1:0] key_square(string s);
    logic [SqW-1:0] sq;
    for (int k = 0; k < SqCells; k++) sq[k*CodeW +: CodeW] = CodeW'(s[k] - "A");
    return sq;
  endfunction

  function automatic logic [SqW-1:0] shuffled_square();
    logic [SqW-1:0] sq;
    int             pool[25];
    int             j, t, m;
    m = 0;
    for (int c = 0; c < 26; c++) begin
      if (c != CODE_J) begin
        pool[m] = c;
        m++;
      end
    end
    for (int k = SqCells - 1; k > 0; k--) begin
      j = $urandom_range(k);
      t = pool[k];
      pool[k] = pool[j];
      pool[j] = t;
    end
    for (int k = 0; k < SqCells; k++) sq[k*CodeW +: CodeW] = CodeW'(pool[k]);
    return sq;
  endfunction

  initial begin
    logic [7:0]       ch;
    logic             eot;
    logic             is_l;
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] prev;
    logic             have_prev;
    logic             dec;
    logic [SqW-1:0]   sq;
    int               counted;

    mode_dec    = 1'b0;
    key_sq      = '0;
    held_valid  = 1'b0;
    held_letter = '0;
    fails       = 0;
    snd_idle    = 31;
    rcv_idle    = 55;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= CFG_MODE;
    cfg_wdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].setting != NO_SET) begin
        wait_drain();
        set_regs(DIRECTED[r].setting == SET_STD_DEC, key_square(STD_KEY));
      end
      send_word(DIRECTED[r].ch, DIRECTED[r].eot, DIRECTED[r].typed,
                DIRECTED[r].n, DIRECTED[r].codes);
    end

    have_prev = 1'b0;
    prev = '0;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drain();
      case (ph)
        0: begin dec = 1'b0; sq = key_square(STD_KEY); end
        1: begin dec = 1'b1; sq = shuffled_square(); end
        2: begin dec = 1'b0; sq = '1; end
        3: begin dec = 1'($urandom_range(1)); sq = SqW'({$urandom, $urandom, $urandom, $urandom}); end
        4: begin dec = 1'b1; sq = '0; end
        default: begin dec = 1'b0; sq = shuffled_square(); end
      endcase
      set_regs(dec, sq);
      if (ph < 2) begin
        snd_idle = 31;
        rcv_idle = 55;
      end else if (ph < 4) begin
        snd_idle = 55;
        rcv_idle = 31;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if (ph == 1 && counted == 20) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (cipher_letters_q.size() != 0);
        end
        is_l = ($urandom_range(99) < 85);
        if (is_l) begin
          if (have_prev && $urandom_range(99) < 30) code = prev;
          else code = CodeW'($urandom_range(25));
          ch = ($urandom_range(1) ? ASCII_UA : ASCII_LA) + 8'(code);
          prev = code;
          have_prev = 1'b1;
        end else begin
          ch = 8'($urandom_range(255));
        end
        eot = ($urandom_range(99) < 8);
        counted++;
        send_word(ch, eot, 1'b0, 0, '0);
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (cipher_letters_q.size() != 0);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
